FILE: src/tcbe_pkg.sv
// ----------------------------------------------------------------------------
// tcbe_pkg
// Shared constants, command codes and controller/datapath interface types
// for the text cell buffer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbe_pkg;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 32;
    localparam int STORE_CELLS = 4096;

    localparam int POS_W      = 8;
    localparam int COL_W      = $clog2(MAX_COLS + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS + 1);
    localparam int IDX_W      = $clog2(STORE_CELLS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COUNT_W    = 13;
    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int SCROLL_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_COLS_W = 8;
    localparam int CFG_ROWS_W = 6;

    localparam logic [CMD_W-1:0] CMD_RD_CELL    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_CELL    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RD_ATTR    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_ATTR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FILL       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SCROLL     = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR = 2'd2;

    localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 6'd25;

    localparam logic [1:0] MSEL_FIRST  = 2'd0;
    localparam logic [1:0] MSEL_SECOND = 2'd1;
    localparam logic [1:0] MSEL_AREA   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       cap_a;
        logic       cap_b;
        logic       cap_area;
        logic       access;
        logic       plan;
        logic       plan2;
        logic       move_rd;
        logic       fill_wr;
        logic       clr_wr;
        logic       load_out;
    } tcbe_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             move_busy;
        logic             move_last;
        logic             fill_en;
        logic             fill_last;
        logic             clr_last;
    } tcbe_stat_t;

endpackage

`default_nettype wire

FILE: src/text_cell_buffer_engine_core.sv
// ----------------------------------------------------------------------------
// text_cell_buffer_engine_core
// Text-mode cell buffer with cell and attribute stores, move, fill, scroll
// and cursor commands. One result per command.
//
// Channel   Handshake            Payload
// cfg       cfg_we               cfg_index, cfg_data
// in        in_valid / in_stall  cmd, pos_x .. scroll_rows
// out       out_valid / out_stall read_char .. shown_cursor_y
//
// Single-cell reads, writes and set cursor pass through the index setup
// states to the result; move, fill and scroll add planning states, a copy
// state and a fill state that step through the cells, and a drain state for
// the last copy write. The memory ports set the pace. After reset a clearing
// pass zeroes both stores; input is stalled until it ends. A finished
// result waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_buffer_engine_core
    import tcbe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [POS_W-1:0]      pos_x,
    input  wire logic [POS_W-1:0]      pos_y,
    input  wire logic [POS_W-1:0]      to_x,
    input  wire logic [POS_W-1:0]      to_y,
    input  wire logic [COUNT_W-1:0]    cell_count,
    input  wire logic [BYTE_W-1:0]     char_code,
    input  wire logic [BYTE_W-1:0]     char_color,
    input  wire logic [WORD_W-1:0]     attr_word,
    input  wire logic signed [SCROLL_W-1:0] scroll_rows,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          read_char,
    output logic [BYTE_W-1:0]          read_color,
    output logic [WORD_W-1:0]          read_attr,
    output logic [POS_W-1:0]           shown_cursor_x,
    output logic [POS_W-1:0]           shown_cursor_y
);

    tcbe_ctl_t  ctl;
    tcbe_stat_t stat;

    tcbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    tcbe_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .to_x           (to_x),
        .to_y           (to_y),
        .cell_count     (cell_count),
        .char_code      (char_code),
        .char_color     (char_color),
        .attr_word      (attr_word),
        .scroll_rows    (scroll_rows),
        .ctl            (ctl),
        .stat           (stat),
        .read_char      (read_char),
        .read_color     (read_color),
        .read_attr      (read_attr),
        .shown_cursor_x (shown_cursor_x),
        .shown_cursor_y (shown_cursor_y)
    );

endmodule

`default_nettype wire

FILE: src/tcbe_ctrl.sv
// ----------------------------------------------------------------------------
// tcbe_ctrl
// Sequencing state machine: clearing pass, index setup, move, fill and
// result handoff through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbe_ctrl
    import tcbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire tcbe_stat_t stat,
    output tcbe_ctl_t       ctl
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_M4    = 4'd5;
    localparam logic [3:0] S_PLAN  = 4'd6;
    localparam logic [3:0] S_PLAN2 = 4'd7;
    localparam logic [3:0] S_MOVE  = 4'd8;
    localparam logic [3:0] S_DRAIN = 4'd9;
    localparam logic [3:0] S_FILL  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MSEL_FIRST;
                state_next  = S_M2;
            end
            S_M2:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MSEL_SECOND;
                ctl.cap_a   = 1'b1;
                ctl.access  = 1'b1;
                if (stat.cmd inside {CMD_MOVE, CMD_FILL, CMD_SCROLL})
                begin
                    state_next = S_M3;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_M3:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MSEL_AREA;
                ctl.cap_b   = 1'b1;
                state_next  = S_M4;
            end
            S_M4:
            begin
                ctl.cap_area = 1'b1;
                state_next   = S_PLAN;
            end
            S_PLAN:
            begin
                ctl.plan   = 1'b1;
                state_next = S_PLAN2;
            end
            S_PLAN2:
            begin
                ctl.plan2 = 1'b1;
                if (stat.move_busy)
                begin
                    state_next = S_MOVE;
                end
                else if (stat.fill_en)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE:
            begin
                ctl.move_rd = 1'b1;
                if (stat.move_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.fill_en)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                ctl.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/tcbe_datapath.sv
// ----------------------------------------------------------------------------
// tcbe_datapath
// Configuration registers, command latches, shared index multiplier, move
// and fill address generators, the cell and attribute memories, the cursor
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbe_datapath
    import tcbe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [POS_W-1:0]      pos_x,
    input  wire logic [POS_W-1:0]      pos_y,
    input  wire logic [POS_W-1:0]      to_x,
    input  wire logic [POS_W-1:0]      to_y,
    input  wire logic [COUNT_W-1:0]    cell_count,
    input  wire logic [BYTE_W-1:0]     char_code,
    input  wire logic [BYTE_W-1:0]     char_color,
    input  wire logic [WORD_W-1:0]     attr_word,
    input  wire logic signed [SCROLL_W-1:0] scroll_rows,
    input  wire tcbe_ctl_t             ctl,
    output tcbe_stat_t                 stat,
    output logic [BYTE_W-1:0]          read_char,
    output logic [BYTE_W-1:0]          read_color,
    output logic [WORD_W-1:0]          read_attr,
    output logic [POS_W-1:0]           shown_cursor_x,
    output logic [POS_W-1:0]           shown_cursor_y
);

    localparam int WIDE_W = CNT_W + COUNT_W;

    logic [CFG_COLS_W-1:0] cols_cfg_reg;
    logic [CFG_ROWS_W-1:0] rows_cfg_reg;
    logic                  shown_cfg_reg;

    logic [CMD_W-1:0]    cmd_reg;
    logic [POS_W-1:0]    px_reg;
    logic [POS_W-1:0]    py_reg;
    logic [POS_W-1:0]    tx_reg;
    logic [POS_W-1:0]    ty_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0]   char_reg;
    logic [BYTE_W-1:0]   color_reg;
    logic [WORD_W-1:0]   attr_reg;
    logic [SCROLL_W-1:0] sraw_reg;

    logic [CNT_W-1:0] prod_reg;
    logic [CNT_W-1:0] idx_a_reg;
    logic [CNT_W-1:0] idx_b_reg;
    logic [CNT_W-1:0] area_reg;

    logic [IDX_W-1:0]  mv_src_reg;
    logic [IDX_W-1:0]  mv_dst_reg;
    logic [CNT_W-1:0]  mv_rem_reg;
    logic              mv_fwd_reg;
    logic [IDX_W-1:0]  fill_ptr_reg;
    logic [IDX_W-1:0]  fill_end_reg;
    logic              fill_en_reg;
    logic [WORD_W-1:0] fill_attr_reg;
    logic [IDX_W-1:0]  clr_ptr_reg;
    logic              wr_pend_reg;
    logic [IDX_W-1:0]  wr_addr_reg;
    logic              rd_ok_reg;

    logic [POS_W-1:0] cursor_col_reg;
    logic [POS_W-1:0] cursor_row_reg;

    logic [WORD_W-1:0] cell_rd_reg;
    logic [WORD_W-1:0] attr_rd_reg;

    logic [BYTE_W-1:0] read_char_reg;
    logic [BYTE_W-1:0] read_color_reg;
    logic [WORD_W-1:0] read_attr_reg;
    logic [POS_W-1:0]  cur_x_reg;
    logic [POS_W-1:0]  cur_y_reg;

    logic [WORD_W-1:0] cell_mem [STORE_CELLS];
    logic [WORD_W-1:0] attr_mem [STORE_CELLS];

    logic [COL_W-1:0]        cols_act;
    logic [ROW_W-1:0]        rows_act;
    logic [ROW_W-1:0]        rows_m1;
    logic [POS_W-1:0]        xp_c;
    logic [POS_W-1:0]        xt_c;
    logic [ROW_W-1:0]        yp_c;
    logic [ROW_W-1:0]        yt_c;
    logic                    is_scroll;
    logic                    scroll_up;
    logic                    scroll_on;
    logic [SCROLL_W-1:0]     mag_raw;
    logic [ROW_W-1:0]        mag;
    logic [ROW_W-1:0]        mul_a;
    logic [ROW_W+COL_W-1:0]  prod_full;
    logic [CNT_W-1:0]        x_off_a;
    logic [CNT_W-1:0]        x_off_b;
    logic [CNT_W-1:0]        sum_a;
    logic [IDX_W-1:0]        acc_addr;
    logic                    usable;

    logic [CNT_W-1:0]  hi;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  keep;
    logic [CNT_W-1:0]  area_m1;
    logic [CNT_W-1:0]  a_m1;
    logic [WIDE_W-1:0] cnt_w;
    logic [WIDE_W-1:0] avail_w;
    logic [IDX_W-1:0]  pl_src;
    logic [IDX_W-1:0]  pl_dst;
    logic [CNT_W-1:0]  pl_rem;
    logic              pl_fwd;
    logic [IDX_W-1:0]  pl_fill_start;
    logic [IDX_W-1:0]  pl_fill_end;
    logic              pl_fill_en;
    logic [WORD_W-1:0] pl_fill_attr;
    logic [CNT_W-1:0]  rem_m1;

    logic              cell_we;
    logic              attr_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [WORD_W-1:0] cell_wd;
    logic [WORD_W-1:0] attr_wd;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg  <= COLS_RESET;
            rows_cfg_reg  <= ROWS_RESET;
            shown_cfg_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLS:   cols_cfg_reg  <= cfg_data[CFG_COLS_W-1:0];
                CFG_ROWS:   rows_cfg_reg  <= cfg_data[CFG_ROWS_W-1:0];
                CFG_CURSOR: shown_cfg_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            cols_act = COL_W'(1);
        end
        else if (COL_W'(cols_cfg_reg) > COL_W'(MAX_COLS))
        begin
            cols_act = COL_W'(MAX_COLS);
        end
        else
        begin
            cols_act = COL_W'(cols_cfg_reg);
        end

        if (rows_cfg_reg == '0)
        begin
            rows_act = ROW_W'(1);
        end
        else if (ROW_W'(rows_cfg_reg) > ROW_W'(MAX_ROWS))
        begin
            rows_act = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows_act = ROW_W'(rows_cfg_reg);
        end
    end

    assign rows_m1 = rows_act - ROW_W'(1);

    assign xp_c = (px_reg >= POS_W'(cols_act)) ? POS_W'(cols_act - COL_W'(1)) : px_reg;
    assign xt_c = (tx_reg >= POS_W'(cols_act)) ? POS_W'(cols_act - COL_W'(1)) : tx_reg;
    assign yp_c = (py_reg >= POS_W'(rows_act)) ? rows_m1 : py_reg[ROW_W-1:0];
    assign yt_c = (ty_reg >= POS_W'(rows_act)) ? rows_m1 : ty_reg[ROW_W-1:0];

    assign is_scroll = (cmd_reg == CMD_SCROLL);
    assign scroll_up = ~sraw_reg[SCROLL_W-1];
    assign scroll_on = (sraw_reg != '0);
    assign mag_raw   = scroll_up ? sraw_reg : (SCROLL_W'(0) - sraw_reg);
    assign mag       = (mag_raw > SCROLL_W'(rows_act)) ? rows_act : mag_raw[ROW_W-1:0];

    always_comb
    begin
        case (ctl.mul_sel)
            MSEL_FIRST:  mul_a = is_scroll ? mag : yp_c;
            MSEL_SECOND: mul_a = is_scroll ? rows_act : yt_c;
            default:     mul_a = rows_act;
        endcase
    end

    assign prod_full = (ROW_W+COL_W)'(mul_a) * (ROW_W+COL_W)'(cols_act);

    assign x_off_a  = is_scroll ? '0 : CNT_W'(xp_c);
    assign x_off_b  = is_scroll ? '0 : CNT_W'(xt_c);
    assign sum_a    = prod_reg + x_off_a;
    assign acc_addr = sum_a[IDX_W-1:0];
    assign usable   = (px_reg < POS_W'(cols_act)) && (py_reg < POS_W'(rows_act));

    assign hi      = (idx_a_reg > idx_b_reg) ? idx_a_reg : idx_b_reg;
    assign avail   = area_reg - hi;
    assign keep    = area_reg - idx_a_reg;
    assign area_m1 = area_reg - CNT_W'(1);
    assign a_m1    = idx_a_reg - CNT_W'(1);
    assign cnt_w   = WIDE_W'(cnt_reg);
    assign avail_w = WIDE_W'(avail);

    always_comb
    begin
        pl_src        = idx_a_reg[IDX_W-1:0];
        pl_dst        = idx_b_reg[IDX_W-1:0];
        pl_rem        = '0;
        pl_fwd        = 1'b1;
        pl_fill_start = idx_a_reg[IDX_W-1:0];
        pl_fill_end   = idx_b_reg[IDX_W-1:0];
        pl_fill_en    = 1'b0;
        pl_fill_attr  = attr_reg;
        case (cmd_reg)
            CMD_MOVE:
            begin
                if (idx_a_reg != idx_b_reg)
                begin
                    pl_rem = (cnt_w < avail_w) ? CNT_W'(cnt_reg) : avail;
                end
                pl_fwd = (idx_b_reg < idx_a_reg);
            end
            CMD_FILL:
            begin
                pl_fill_en = (idx_a_reg <= idx_b_reg);
            end
            CMD_SCROLL:
            begin
                if (scroll_on)
                begin
                    pl_rem       = keep;
                    pl_fill_en   = 1'b1;
                    pl_fill_attr = '0;
                    if (scroll_up)
                    begin
                        pl_src        = idx_a_reg[IDX_W-1:0];
                        pl_dst        = '0;
                        pl_fwd        = 1'b1;
                        pl_fill_start = keep[IDX_W-1:0];
                        pl_fill_end   = area_m1[IDX_W-1:0];
                    end
                    else
                    begin
                        pl_src        = '0;
                        pl_dst        = idx_a_reg[IDX_W-1:0];
                        pl_fwd        = 1'b0;
                        pl_fill_start = '0;
                        pl_fill_end   = a_m1[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rem_m1 = mv_rem_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= cmd;
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            tx_reg    <= to_x;
            ty_reg    <= to_y;
            cnt_reg   <= cell_count;
            char_reg  <= char_code;
            color_reg <= char_color;
            attr_reg  <= attr_word;
            sraw_reg  <= scroll_rows;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= prod_full[CNT_W-1:0];
        end
        if (ctl.cap_a)
        begin
            idx_a_reg <= sum_a;
        end
        if (ctl.cap_b)
        begin
            idx_b_reg <= prod_reg + x_off_b;
        end
        if (ctl.cap_area)
        begin
            area_reg <= prod_reg;
        end
        if (ctl.access)
        begin
            rd_ok_reg <= usable;
        end
        if (ctl.plan)
        begin
            mv_src_reg    <= pl_src;
            mv_dst_reg    <= pl_dst;
            mv_rem_reg    <= pl_rem;
            mv_fwd_reg    <= pl_fwd;
            fill_ptr_reg  <= pl_fill_start;
            fill_end_reg  <= pl_fill_end;
            fill_en_reg   <= pl_fill_en;
            fill_attr_reg <= pl_fill_attr;
        end
        else if (ctl.plan2)
        begin
            if (!mv_fwd_reg)
            begin
                mv_src_reg <= mv_src_reg + rem_m1[IDX_W-1:0];
                mv_dst_reg <= mv_dst_reg + rem_m1[IDX_W-1:0];
            end
        end
        else if (ctl.move_rd)
        begin
            mv_rem_reg  <= rem_m1;
            wr_addr_reg <= mv_dst_reg;
            if (mv_fwd_reg)
            begin
                mv_src_reg <= mv_src_reg + IDX_W'(1);
                mv_dst_reg <= mv_dst_reg + IDX_W'(1);
            end
            else
            begin
                mv_src_reg <= mv_src_reg - IDX_W'(1);
                mv_dst_reg <= mv_dst_reg - IDX_W'(1);
            end
        end
        if (ctl.fill_wr)
        begin
            fill_ptr_reg <= fill_ptr_reg + IDX_W'(1);
        end
        if (ctl.load_out)
        begin
            read_char_reg  <= (cmd_reg == CMD_RD_CELL && rd_ok_reg) ?
                              cell_rd_reg[BYTE_W-1:0] : '0;
            read_color_reg <= (cmd_reg == CMD_RD_CELL && rd_ok_reg) ?
                              cell_rd_reg[WORD_W-1:BYTE_W] : '0;
            read_attr_reg  <= (cmd_reg == CMD_RD_ATTR && rd_ok_reg) ? attr_rd_reg : '0;
            cur_x_reg      <= shown_cfg_reg ? cursor_col_reg : POS_W'(cols_act);
            cur_y_reg      <= shown_cfg_reg ? cursor_row_reg : POS_W'(rows_m1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg    <= '0;
            wr_pend_reg    <= 1'b0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            wr_pend_reg <= ctl.move_rd;
            if (ctl.clr_wr)
            begin
                clr_ptr_reg <= clr_ptr_reg + IDX_W'(1);
            end
            if (ctl.access && cmd_reg == CMD_SET_CURSOR)
            begin
                cursor_col_reg <= px_reg;
                cursor_row_reg <= py_reg;
            end
        end
    end

    always_comb
    begin
        cell_we = 1'b0;
        attr_we = 1'b0;
        mem_wa  = acc_addr;
        cell_wd = {color_reg, char_reg};
        attr_wd = attr_reg;
        if (ctl.clr_wr)
        begin
            cell_we = 1'b1;
            attr_we = 1'b1;
            mem_wa  = clr_ptr_reg;
            cell_wd = '0;
            attr_wd = '0;
        end
        else if (wr_pend_reg)
        begin
            cell_we = 1'b1;
            attr_we = 1'b1;
            mem_wa  = wr_addr_reg;
            cell_wd = cell_rd_reg;
            attr_wd = attr_rd_reg;
        end
        else if (ctl.fill_wr)
        begin
            cell_we = 1'b1;
            attr_we = 1'b1;
            mem_wa  = fill_ptr_reg;
            attr_wd = fill_attr_reg;
        end
        else if (ctl.access && usable)
        begin
            cell_we = (cmd_reg == CMD_WR_CELL);
            attr_we = (cmd_reg == CMD_WR_ATTR);
        end
    end

    assign mem_re = ctl.move_rd ||
                    (ctl.access && (cmd_reg == CMD_RD_CELL || cmd_reg == CMD_RD_ATTR));
    assign mem_ra = ctl.move_rd ? mv_src_reg : acc_addr;

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[mem_wa] <= cell_wd;
        end
        if (attr_we)
        begin
            attr_mem[mem_wa] <= attr_wd;
        end
        if (mem_re)
        begin
            cell_rd_reg <= cell_mem[mem_ra];
            attr_rd_reg <= attr_mem[mem_ra];
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.move_busy = (mv_rem_reg != '0);
    assign stat.move_last = (mv_rem_reg == CNT_W'(1));
    assign stat.fill_en   = fill_en_reg;
    assign stat.fill_last = (fill_ptr_reg == fill_end_reg);
    assign stat.clr_last  = (clr_ptr_reg == IDX_W'(STORE_CELLS - 1));

    assign read_char      = read_char_reg;
    assign read_color     = read_color_reg;
    assign read_attr      = read_attr_reg;
    assign shown_cursor_x = cur_x_reg;
    assign shown_cursor_y = cur_y_reg;

endmodule

`default_nettype wire

FILE: src/tcbe_checker.sv
// ----------------------------------------------------------------------------
// tcbe_checker
// Port-level checks on the text cell buffer engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbe_checker
    import tcbe_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [BYTE_W-1:0]     read_char,
    input wire logic [BYTE_W-1:0]     read_color,
    input wire logic [WORD_W-1:0]     read_attr,
    input wire logic [POS_W-1:0]      shown_cursor_x,
    input wire logic [POS_W-1:0]      shown_cursor_y
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_char) && $stable(read_color) &&
            $stable(read_attr) && $stable(shown_cursor_x) && $stable(shown_cursor_y))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command taken while one is in progress");

    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(((read_char != '0) || (read_color != '0)) && (read_attr != '0)))
        else $error("cell data and attribute both reported in one result");

endmodule

bind text_cell_buffer_engine_core tcbe_checker u_tcbe_checker (.*);

`default_nettype wire
